@@ hdl/stbw_pkg.sv @@
// Shared types and constants for the square-tracing boundary walker.
// No dependencies; every other file of the block imports this package.
package stbw_pkg;

  // Signed grid coordinate: holds -1 .. grid size plus a few off-grid moves.
  localparam int POS_W = 9;
  typedef logic signed [POS_W-1:0] pos_t;

  localparam int SIZE_W  = 7;
  localparam int LEVEL_W = 16;
  localparam int P_W     = 17;
  localparam int COORD_W = 6;

  localparam int MAX_ROWS_DEFAULT    = 64;
  localparam int MAX_COLUMNS_DEFAULT = 64;

  // APB register map
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [1:0] REG_GRID_ROWS      = 2'd0;
  localparam logic [1:0] REG_GRID_COLUMNS   = 2'd1;
  localparam logic [1:0] REG_CRITICAL_LEVEL = 2'd2;

  localparam logic [SIZE_W-1:0]  GRID_ROWS_RESET      = 7'd64;
  localparam logic [SIZE_W-1:0]  GRID_COLUMNS_RESET   = 7'd64;
  localparam logic [LEVEL_W-1:0] CRITICAL_LEVEL_RESET = 16'd3277;

  // Input commands
  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_REQUEST = 2'd0;
  localparam logic [1:0] STATUS_CLOSED  = 2'd1;
  localparam logic [1:0] STATUS_NO_EXCL = 2'd2;
  localparam logic [1:0] STATUS_ERROR   = 2'd3;

  typedef enum logic [1:0] {
    HEAD_WEST  = 2'd0,
    HEAD_NORTH = 2'd1,
    HEAD_EAST  = 2'd2,
    HEAD_SOUTH = 2'd3
  } head_t;

  typedef struct packed {
    logic         command;
    logic [P_W-1:0] p_value;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] next_row;
    logic [COORD_W-1:0] next_column;
    logic               finished;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic [SIZE_W-1:0]  grid_rows;
    logic [SIZE_W-1:0]  grid_columns;
    logic [LEVEL_W-1:0] critical_level;
  } cfg_t;

  typedef struct packed {
    pos_t       cur_row;
    pos_t       cur_column;
    head_t      heading;
    pos_t       first_hit_row;
    pos_t       first_hit_column;
    logic       first_hit_known;
    logic [1:0] revisit_count;
    logic       walking;
  } walk_state_t;

endpackage

@@ hdl/stbw_if.sv @@
// Valid/ready channel interfaces for walker commands and walker results.
// Depends on stbw_pkg for the item types.
interface stbw_in_if;
  import stbw_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface stbw_out_if;
  import stbw_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

@@ hdl/stbw_cfg_regs.sv @@
// APB register file: grid_rows, grid_columns, critical_level.
// Depends on stbw_pkg for the register map and the cfg_t bundle.
module stbw_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [stbw_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [stbw_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [stbw_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output stbw_pkg::cfg_t                    cfg
);
  import stbw_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_rows      <= GRID_ROWS_RESET;
      cfg_r.grid_columns   <= GRID_COLUMNS_RESET;
      cfg_r.critical_level <= CRITICAL_LEVEL_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_GRID_ROWS:      cfg_r.grid_rows      <= pwdata[SIZE_W-1:0];
        REG_GRID_COLUMNS:   cfg_r.grid_columns   <= pwdata[SIZE_W-1:0];
        REG_CRITICAL_LEVEL: cfg_r.critical_level <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GRID_ROWS:      prdata = CFG_DATA_W'(cfg_r.grid_rows);
      REG_GRID_COLUMNS:   prdata = CFG_DATA_W'(cfg_r.grid_columns);
      REG_CRITICAL_LEVEL: prdata = CFG_DATA_W'(cfg_r.critical_level);
      default:            prdata = '0;
    endcase
  end

endmodule

@@ hdl/stbw_walk_step.sv @@
// One walker step: next walker state and the result item for one command.
// Pure combinational; depends on stbw_pkg for state, config and item types.
module stbw_walk_step #(
  parameter int MAX_ROWS    = stbw_pkg::MAX_ROWS_DEFAULT,
  parameter int MAX_COLUMNS = stbw_pkg::MAX_COLUMNS_DEFAULT
) (
  input  stbw_pkg::cfg_t        cfg,
  input  stbw_pkg::in_item_t    item,
  input  stbw_pkg::walk_state_t st,
  output stbw_pkg::walk_state_t st_nxt,
  output stbw_pkg::out_item_t   res
);
  import stbw_pkg::*;

  // Size registers are 7 bits, so a bound above 127 never clamps.
  localparam int RowCapInt = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
  localparam int ColCapInt = (MAX_COLUMNS > 127) ? 127 : MAX_COLUMNS;
  localparam logic [SIZE_W-1:0] ROW_CAP = SIZE_W'(RowCapInt);
  localparam logic [SIZE_W-1:0] COL_CAP = SIZE_W'(ColCapInt);

  logic [SIZE_W-1:0] rows_eff;
  logic [SIZE_W-1:0] cols_eff;
  pos_t              rows_p;
  pos_t              cols_p;
  logic              excl;
  logic              above;

  always_comb begin
    if (cfg.grid_rows == '0)        rows_eff = SIZE_W'(1);
    else if (cfg.grid_rows > ROW_CAP) rows_eff = ROW_CAP;
    else                              rows_eff = cfg.grid_rows;
    if (cfg.grid_columns == '0)         cols_eff = SIZE_W'(1);
    else if (cfg.grid_columns > COL_CAP) cols_eff = COL_CAP;
    else                                 cols_eff = cfg.grid_columns;
  end

  assign rows_p = pos_t'({2'b00, rows_eff});
  assign cols_p = pos_t'({2'b00, cols_eff});
  assign excl   = item.p_value < {1'b0, cfg.critical_level};
  assign above  = item.p_value > {1'b0, cfg.critical_level};

  function automatic logic on_grid(pos_t r, pos_t c, pos_t nr, pos_t nc);
    return (r >= 0) && (c >= 0) && (r < nr) && (c < nc);
  endfunction

  function automatic walk_state_t advance(walk_state_t s);
    walk_state_t t;
    t = s;
    case (s.heading)
      HEAD_WEST:  t.cur_column = s.cur_column - pos_t'(1);
      HEAD_NORTH: t.cur_row    = s.cur_row + pos_t'(1);
      HEAD_EAST:  t.cur_column = s.cur_column + pos_t'(1);
      HEAD_SOUTH: t.cur_row    = s.cur_row - pos_t'(1);
      default:    t = s;
    endcase
    return t;
  endfunction

  function automatic out_item_t finish(logic [1:0] code);
    out_item_t o;
    o.next_row    = '0;
    o.next_column = '0;
    o.finished    = 1'b1;
    o.status      = code;
    return o;
  endfunction

  always_comb begin
    walk_state_t s;
    logic        closed;
    s      = st;
    closed = 1'b0;
    res    = finish(STATUS_ERROR);

    if (item.command == CMD_START) begin
      s.cur_row          = rows_p - pos_t'(1);
      s.cur_column       = cols_p - pos_t'(1);
      s.heading          = HEAD_WEST;
      s.first_hit_row    = '0;
      s.first_hit_column = '0;
      s.first_hit_known  = 1'b0;
      s.revisit_count    = '0;
      s.walking          = 1'b1;
      res.next_row    = s.cur_row[COORD_W-1:0];
      res.next_column = s.cur_column[COORD_W-1:0];
      res.finished    = 1'b0;
      res.status      = STATUS_REQUEST;
    end else if (!st.walking) begin
      res = finish(STATUS_ERROR);
    end else if (!st.first_hit_known && above &&
                 st.cur_row == rows_p - pos_t'(1) && st.cur_column == '0) begin
      s.walking = 1'b0;
      res = finish(STATUS_NO_EXCL);
    end else begin
      if (!s.first_hit_known && excl) begin
        s.first_hit_known  = 1'b1;
        s.first_hit_row    = s.cur_row;
        s.first_hit_column = s.cur_column;
      end
      if (s.first_hit_known && s.cur_row == s.first_hit_row &&
          s.cur_column == s.first_hit_column) begin
        s.revisit_count = s.revisit_count + 2'd1;
        if (s.revisit_count >= 2'd2) begin
          closed    = 1'b1;
          s.walking = 1'b0;
          res = finish(STATUS_CLOSED);
        end
      end
      if (!closed) begin
        if (!s.first_hit_known) begin
          s = advance(s);
        end else begin
          // left turn on an excluded point, right turn otherwise
          s.heading = excl ? head_t'(2'(s.heading + 2'd3)) : head_t'(2'(s.heading + 2'd1));
          s = advance(s);
          // off-grid points read as not excluded: keep turning right
          for (int i = 0; i < 4; i++) begin
            if (!on_grid(s.cur_row, s.cur_column, rows_p, cols_p)) begin
              s.heading = head_t'(2'(s.heading + 2'd1));
              s = advance(s);
            end
          end
        end
        if (!on_grid(s.cur_row, s.cur_column, rows_p, cols_p)) begin
          s.walking = 1'b0;
          res = finish(STATUS_ERROR);
        end else begin
          res.next_row    = s.cur_row[COORD_W-1:0];
          res.next_column = s.cur_column[COORD_W-1:0];
          res.finished    = 1'b0;
          res.status      = STATUS_REQUEST;
        end
      end
    end
    st_nxt = s;
  end

endmodule

@@ hdl/square_tracing_boundary_walker_core.sv @@
// Square-tracing boundary walker. A start item places the walker at the
// top-right grid point and requests it; each report item carries the p-value
// of the requested point and yields exactly one result item: the next point
// to request, or a finish code (contour closed, no exclusion in top row,
// error). One item is accepted every cycle while the result register is free
// (a stalled result holds the flow): the input register feeds a combinational
// step (compares, a heading turn and at most five fixed moves) that updates the
// walker state and the result register at the same edge. The APB registers are
// taken to be written only while no item is in flight.
module square_tracing_boundary_walker_core #(
  parameter int MAX_ROWS    = stbw_pkg::MAX_ROWS_DEFAULT,
  parameter int MAX_COLUMNS = stbw_pkg::MAX_COLUMNS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  stbw_in_if.sink                           in_ch,
  stbw_out_if.source                        out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [stbw_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [stbw_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [stbw_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import stbw_pkg::*;

  cfg_t        cfg;
  in_item_t    in_item_r;
  logic        in_valid_r;
  out_item_t   out_item_r;
  out_item_t   out_item_nxt;
  logic        out_valid_r;
  walk_state_t walk_r;
  walk_state_t walk_nxt;
  logic        out_free;
  logic        step_en;
  logic        in_ready;

  stbw_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  stbw_walk_step #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_walk_step (
    .cfg    (cfg),
    .item   (in_item_r),
    .st     (walk_r),
    .st_nxt (walk_nxt),
    .res    (out_item_nxt)
  );

  assign out_free     = !out_valid_r || out_ch.ready;
  assign step_en      = in_valid_r && out_free;
  assign in_ready     = !in_valid_r || out_free;
  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      walk_r.cur_row          <= '0;
      walk_r.cur_column       <= '0;
      walk_r.heading          <= HEAD_WEST;
      walk_r.first_hit_row    <= '0;
      walk_r.first_hit_column <= '0;
      walk_r.first_hit_known  <= 1'b0;
      walk_r.revisit_count    <= '0;
      walk_r.walking          <= 1'b0;
    end else begin
      if (in_ready) in_valid_r <= in_ch.valid;
      if (out_free) out_valid_r <= step_en;
      if (step_en) walk_r <= walk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) in_item_r <= in_ch.item;
    if (step_en) out_item_r <= out_item_nxt;
  end

endmodule

@@ bench/square_tracing_boundary_walker_core_tb.sv @@
// Self-checking bench for square_tracing_boundary_walker_core: walks over random
// excluded regions, noise items and directed corner cases, checked item by item.
// Depends on stbw_pkg and the stbw_in_if / stbw_out_if channel interfaces.
module square_tracing_boundary_walker_core_tb;
  import stbw_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int WALK_CAP     = 150;

  typedef struct {
    int         row;
    int         col;
    head_t      dir;
    int         hit_row;
    int         hit_col;
    bit         hit_known;
    logic [1:0] visits;
    bit         active;
  } tracer_t;

  logic clk;
  logic rst_n;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  stbw_in_if  in_ch ();
  stbw_out_if out_ch ();

  square_tracing_boundary_walker_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // register copies, shared by the stimulus planner and the result predictor
  logic [SIZE_W-1:0]  rows_cfg  = GRID_ROWS_RESET;
  logic [SIZE_W-1:0]  cols_cfg  = GRID_COLUMNS_RESET;
  logic [LEVEL_W-1:0] level_cfg = CRITICAL_LEVEL_RESET;

  tracer_t   plan_st;
  tracer_t   model_st;
  in_item_t  pending[$];
  out_item_t expected_q[$];
  int        in_flight   = 0;
  int        items_sent  = 0;
  int        fail_count  = 0;
  int        cycle_count = 0;
  int        send_idle   = 27;
  int        recv_idle   = 76;
  bit        blocked [0:63][0:63];

  function automatic int clamp_size(logic [SIZE_W-1:0] v, int bound);
    if (v == 0)
      return 1;
    if (v > bound)
      return bound;
    return int'(v);
  endfunction

  function automatic bit on_grid(int r, int c);
    return r >= 0 && c >= 0 && r < clamp_size(rows_cfg, MAX_ROWS_DEFAULT) &&
           c < clamp_size(cols_cfg, MAX_COLUMNS_DEFAULT);
  endfunction

  function automatic void step_ahead(ref tracer_t s);
    case (s.dir)
      HEAD_WEST:  s.col--;
      HEAD_NORTH: s.row++;
      HEAD_EAST:  s.col++;
      default:    s.row--;
    endcase
  endfunction

  function automatic void veer(ref tracer_t s, input bit left);
    logic [1:0] d;
    d = left ? s.dir - 2'd1 : s.dir + 2'd1;
    s.dir = head_t'(d);
    step_ahead(s);
  endfunction

  function automatic out_item_t walk_result(tracer_t s, bit fin, logic [1:0] code);
    out_item_t r;
    r = '0;
    if (!fin) begin
      r.next_row    = COORD_W'(s.row);
      r.next_column = COORD_W'(s.col);
    end
    r.finished = fin;
    r.status   = code;
    return r;
  endfunction

  function automatic tracer_t idle_tracer();
    tracer_t s;
    s.row = 0; s.col = 0; s.dir = HEAD_WEST;
    s.hit_row = 0; s.hit_col = 0; s.hit_known = 1'b0;
    s.visits = 2'd0; s.active = 1'b0;
    return s;
  endfunction

  // one walker step: updates the tracer and returns the result item it produces
  function automatic out_item_t trace_step(ref tracer_t s, input in_item_t it);
    int rows_e;
    int cols_e;
    int i;
    rows_e = clamp_size(rows_cfg, MAX_ROWS_DEFAULT);
    cols_e = clamp_size(cols_cfg, MAX_COLUMNS_DEFAULT);
    if (it.command == CMD_START) begin
      s.row = rows_e - 1; s.col = cols_e - 1; s.dir = HEAD_WEST;
      s.hit_row = 0; s.hit_col = 0; s.hit_known = 1'b0;
      s.visits = 2'd0; s.active = 1'b1;
      return walk_result(s, 1'b0, STATUS_REQUEST);
    end
    if (!s.active)
      return walk_result(s, 1'b1, STATUS_ERROR);
    if (!s.hit_known && it.p_value > level_cfg && s.row == rows_e - 1 && s.col == 0) begin
      s.active = 1'b0;
      return walk_result(s, 1'b1, STATUS_NO_EXCL);
    end
    if (!s.hit_known && it.p_value < level_cfg) begin
      s.hit_known = 1'b1;
      s.hit_row   = s.row;
      s.hit_col   = s.col;
    end
    if (s.hit_known && s.row == s.hit_row && s.col == s.hit_col) begin
      s.visits = s.visits + 2'd1;
      if (s.visits >= 2) begin
        s.active = 1'b0;
        return walk_result(s, 1'b1, STATUS_CLOSED);
      end
    end
    if (!s.hit_known) begin
      step_ahead(s);
      if (!on_grid(s.row, s.col)) begin
        s.active = 1'b0;
        return walk_result(s, 1'b1, STATUS_ERROR);
      end
      return walk_result(s, 1'b0, STATUS_REQUEST);
    end
    veer(s, it.p_value < level_cfg);
    // off-grid points read as p = 1: keep turning right
    for (i = 0; i < 4 && !on_grid(s.row, s.col); i++)
      veer(s, 1'b0);
    if (!on_grid(s.row, s.col)) begin
      s.active = 1'b0;
      return walk_result(s, 1'b1, STATUS_ERROR);
    end
    return walk_result(s, 1'b0, STATUS_REQUEST);
  endfunction

  task automatic push_item(logic cmd, logic [P_W-1:0] p);
    in_item_t it;
    it.command = cmd;
    it.p_value = p;
    void'(trace_step(plan_st, it));
    pending.insert(pending.size(), it);
    in_flight++;
    items_sent++;
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (in_flight != 0 || expected_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_GRID_ROWS:    rows_cfg  = val[SIZE_W-1:0];
      REG_GRID_COLUMNS: cols_cfg  = val[SIZE_W-1:0];
      default:          level_cfg = val[LEVEL_W-1:0];
    endcase
  endtask

  // mostly small grids so walks stay short
  function automatic logic [SIZE_W-1:0] pick_side();
    case ($urandom_range(11))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'($urandom_range(127, 64));
      3, 4:    return 7'($urandom_range(63, 11));
      default: return 7'($urandom_range(10, 2));
    endcase
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(16'hFFFF));
      default: return 16'($urandom_range(40000, 1000));
    endcase
  endfunction

  task automatic paint_region();
    int rows_e, cols_e, r0, r1, c0, c1, dens, shape;
    rows_e = clamp_size(rows_cfg, MAX_ROWS_DEFAULT);
    cols_e = clamp_size(cols_cfg, MAX_COLUMNS_DEFAULT);
    shape  = $urandom_range(5);
    r0     = $urandom_range(rows_e - 1);
    r1     = ($urandom_range(3) != 0) ? rows_e - 1 : $urandom_range(rows_e - 1, r0);
    c0     = $urandom_range(cols_e - 1);
    c1     = $urandom_range(cols_e - 1, c0);
    dens   = $urandom_range(70, 10);
    for (int r = 0; r < 64; r++)
      for (int c = 0; c < 64; c++) begin
        case (shape)
          0:       blocked[r][c] = 1'b0;
          1, 2:    blocked[r][c] = r >= r0 && r <= r1 && c >= c0 && c <= c1;
          3:       blocked[r][c] = $urandom_range(99) < dens;
          4:       blocked[r][c] = 1'b1;
          default: blocked[r][c] = (r >= r0 && r <= r1 && c >= c0 && c <= c1) ||
                                   $urandom_range(99) < 8;
        endcase
      end
  endtask

  function automatic logic [P_W-1:0] p_for(int r, int c);
    if (blocked[r][c] && level_cfg > 0)
      return P_W'($urandom_range(level_cfg - 1, 0));
    case ($urandom_range(5))
      0:       return P_W'(level_cfg);
      1:       return 17'h10000;
      2:       return P_W'($urandom_range(17'h1FFFF, 17'h10001));
      default: return P_W'($urandom_range(17'h10000, level_cfg));
    endcase
  endfunction

  // a start and its walk over the painted region, with a little noise mixed in
  task automatic plan_walk();
    int n;
    int roll;
    push_item(CMD_START, P_W'($urandom_range(17'h1FFFF)));
    n = 0;
    while (plan_st.active && n < WALK_CAP) begin
      roll = $urandom_range(99);
      if (roll < 2)
        push_item(CMD_START, P_W'($urandom_range(17'h1FFFF)));
      else if (roll < 5)
        push_item(CMD_REPORT, P_W'($urandom_range(17'h1FFFF)));
      else
        push_item(CMD_REPORT, p_for(plan_st.row, plan_st.col));
      n++;
    end
    if ($urandom_range(3) == 0)
      push_item(CMD_REPORT, P_W'($urandom_range(17'h1FFFF)));
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // input driver; the predictor runs on every accepted item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_q.insert(expected_q.size(), trace_step(model_st, in_ch.item));
        in_flight--;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_ch.item  <= pending.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("result item with no expectation pending");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_ch.item.next_row !== want.next_row) begin
            $error("next_row: expected %0d, got %0d", want.next_row, out_ch.item.next_row);
            fail_count++;
          end
          if (out_ch.item.next_column !== want.next_column) begin
            $error("next_column: expected %0d, got %0d", want.next_column,
                   out_ch.item.next_column);
            fail_count++;
          end
          if (out_ch.item.finished !== want.finished) begin
            $error("finished: expected %0d, got %0d", want.finished, out_ch.item.finished);
            fail_count++;
          end
          if (out_ch.item.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.item.status);
            fail_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    int random_base;
    in_ch.valid  = 1'b0;
    in_ch.item   = '0;
    out_ch.ready = 1'b0;
    rst_n        = 1'b0;
    plan_st      = idle_tracer();
    model_st     = idle_tracer();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset grid: report while idle, forward steps, first hit, turns, restart
    push_item(CMD_REPORT, 17'd0);
    push_item(CMD_START, 17'd0);
    push_item(CMD_REPORT, 17'h1FFFF);
    push_item(CMD_REPORT, 17'h10000);
    push_item(CMD_REPORT, P_W'(CRITICAL_LEVEL_RESET));
    push_item(CMD_REPORT, 17'd0);
    push_item(CMD_REPORT, P_W'(CRITICAL_LEVEL_RESET - 1));
    push_item(CMD_REPORT, 17'h10000);
    push_item(CMD_START, 17'h1FFFF);

    // zero sizes clamp to a single point; top level of 0xFFFF
    wait_idle();
    write_reg(REG_GRID_ROWS, 32'd0);
    write_reg(REG_GRID_COLUMNS, 32'd0);
    write_reg(REG_CRITICAL_LEVEL, 32'hFFFF);
    push_item(CMD_START, 17'd0);
    push_item(CMD_REPORT, 17'hFFFF);      // equal to the level: steps off the grid
    push_item(CMD_START, 17'd0);
    push_item(CMD_REPORT, 17'h10000);     // no exclusion in top row
    push_item(CMD_START, 17'd0);
    push_item(CMD_REPORT, 17'd0);         // hit, then off-grid turns back home
    push_item(CMD_REPORT, 17'hFFFE);      // second visit closes the contour
    push_item(CMD_REPORT, 17'h1FFFF);

    // oversized rows clamp to the bound; level 0 excludes nothing
    wait_idle();
    write_reg(REG_GRID_ROWS, 32'd127);
    write_reg(REG_GRID_COLUMNS, 32'd2);
    write_reg(REG_CRITICAL_LEVEL, 32'd0);
    push_item(CMD_START, 17'd0);
    push_item(CMD_REPORT, 17'd0);
    push_item(CMD_REPORT, 17'd0);
    push_item(CMD_START, 17'd0);
    push_item(CMD_REPORT, 17'd1);
    push_item(CMD_REPORT, 17'd5);

    // grid shrinks under a walk: off-grid resolution runs out of turns
    wait_idle();
    write_reg(REG_GRID_ROWS, 32'd64);
    write_reg(REG_GRID_COLUMNS, 32'd64);
    write_reg(REG_CRITICAL_LEVEL, 32'd3277);
    push_item(CMD_START, 17'd0);
    push_item(CMD_REPORT, 17'd0);
    wait_idle();
    write_reg(REG_GRID_ROWS, 32'd1);
    write_reg(REG_GRID_COLUMNS, 32'd1);
    push_item(CMD_REPORT, 17'd100);

    random_base = items_sent;
    for (int seg = 0; seg < 3; seg++) begin
      wait_idle();
      case (seg)
        0:       begin send_idle = 27; recv_idle = 76; end
        1:       begin send_idle = 76; recv_idle = 27; end
        default: begin send_idle = 0;  recv_idle = 0;  end
      endcase
      while (items_sent - random_base < (seg + 1) * RANDOM_ITEMS / 3) begin
        wait_idle();
        if ($urandom_range(1))
          write_reg(REG_GRID_ROWS, CFG_DATA_W'(pick_side()));
        if ($urandom_range(1))
          write_reg(REG_GRID_COLUMNS, CFG_DATA_W'(pick_side()));
        if ($urandom_range(1))
          write_reg(REG_CRITICAL_LEVEL, CFG_DATA_W'(pick_level()));
        repeat ($urandom_range(4, 1)) begin
          paint_region();
          plan_walk();
        end
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
